### rtl/psv_pkg.sv
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types, codes and constant tables of the polyphonic sine voice engine.
// ----------------------------------------------------------------------------
package psv_pkg;

    localparam int VOICES          = 16;
    localparam int VOICE_BITS      = $clog2(VOICES);
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int SINE_HALF       = SINE_N / 2;
    localparam int SINE_QUARTER    = SINE_N / 4;
    localparam int PHASE_BITS      = 32;
    localparam int LEVEL_BITS      = 24;
    localparam int ACC_BITS        = 29;

    localparam logic [LEVEL_BITS-1:0] ONE_Q23 = 24'd8388608;
    localparam logic [15:0]           GAIN_ONE = 16'd32768;
    localparam logic [15:0]           GAIN_RESET = 16'd9830;
    localparam logic [31:0]           PHASE_SCALE_RESET = 32'd39370534;
    localparam logic [23:0]           ATTACK_RESET = 24'd34953;
    localparam logic [23:0]           RELEASE_RESET = 24'd874;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ON     = 3'd1;
    localparam logic [2:0] MODE_OFF    = 3'd2;
    localparam logic [2:0] MODE_CHOKE  = 3'd3;
    localparam logic [2:0] MODE_MIDI   = 3'd4;
    localparam logic [2:0] MODE_GAIN   = 3'd5;

    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

    localparam logic [1:0] STAGE_ATTACK  = 2'd0;
    localparam logic [1:0] STAGE_SUSTAIN = 2'd1;
    localparam logic [1:0] STAGE_RELEASE = 2'd2;

    localparam logic [1:0] REG_PHASE_SCALE = 2'd0;
    localparam logic [1:0] REG_ATTACK      = 2'd1;
    localparam logic [1:0] REG_RELEASE     = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ON,
        OP_OFF,
        OP_CHOKE,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PITCH,
        ST_ROUND,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  active;
        logic [6:0]            key;
        logic signed [31:0]    tag;
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] incr;
        logic [LEVEL_BITS-1:0] level;
        logic [1:0]            stage;
    } voice_t;

    typedef struct packed {
        op_t                   op;
        logic signed [7:0]     key;
        logic signed [31:0]    tag;
        logic [VOICE_BITS-1:0] slot;
        logic [VOICE_BITS-1:0] target;
        logic [PHASE_BITS-1:0] incr;
        logic [LEVEL_BITS-1:0] up;
        logic [LEVEL_BITS-1:0] down;
    } head_ctl_t;

    typedef struct packed {
        logic                       valid;
        logic [SINE_TABLE_BITS-1:0] idx;
        logic [LEVEL_BITS-1:0]      level;
    } mix_entry_t;

    typedef logic signed [23:0] sine_rom_t [SINE_N];
    typedef logic [8:0]         key_tab_t [128];

    localparam logic [16:0] SEMI_Q16 [12] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    // Restoring shift-and-subtract quotient, used only while building tables.
    function automatic longint unsigned long_div(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            r = (r << 1) | ((num >> b) & 64'd1);
            if (r >= den)
            begin
                r = r - den;
                q = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t         rom;
        longint unsigned   x;
        longint unsigned   term;
        longint            sum;
        longint unsigned   v;
        int                j;
        for (int i = 0; i < SINE_N; i++)
        begin
            j = i & (SINE_HALF - 1);
            if (j > SINE_QUARTER)
            begin
                j = SINE_HALF - j;
            end
            x = (longint'(j) * 64'd6746518852 + longint'(SINE_HALF)) >> SINE_TABLE_BITS;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 9; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = long_div(term, 64'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (longint'(sum) + 64) >> 7;
            if (v > 64'd8388607)
            begin
                v = 64'd8388607;
            end
            rom[i] = (i >= SINE_HALF) ? -$signed(v[23:0]) : $signed(v[23:0]);
        end
        return rom;
    endfunction

    // Each entry holds the semitone in the upper four bits and the shift below.
    function automatic key_tab_t build_key_tab();
        key_tab_t tab;
        int d;
        int oct;
        int semi;
        for (int k = 0; k < 128; k++)
        begin
            d = k - 69;
            oct = -6;
            for (int o = -5; o <= 4; o++)
            begin
                if (d >= 12 * o)
                begin
                    oct = o;
                end
            end
            semi = d - 12 * oct;
            tab[k] = {4'(semi), 5'(16 - oct)};
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam key_tab_t  KEY_TAB  = build_key_tab();

endpackage

### rtl/psv_in_if.sv
// ----------------------------------------------------------------------------
// psv_in_if
// Event channel into the voice engine.
// ----------------------------------------------------------------------------
interface psv_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic signed [7:0]  note_key;
    logic signed [31:0] note_tag;
    logic [7:0]         midi_status;
    logic [6:0]         midi_data1;
    logic [6:0]         midi_data2;
    logic [15:0]        gain_value;

    modport source (output valid, mode, note_key, note_tag, midi_status, midi_data1,
                    midi_data2, gain_value, input ready);
    modport sink (input valid, mode, note_key, note_tag, midi_status, midi_data1,
                  midi_data2, gain_value, output ready);
endinterface

### rtl/psv_out_if.sv
// ----------------------------------------------------------------------------
// psv_out_if
// Sample channel out of the voice engine.
// ----------------------------------------------------------------------------
interface psv_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;
    logic [4:0]         voices_busy;

    modport source (output valid, sample_out, voices_busy, input ready);
    modport sink (input valid, sample_out, voices_busy, output ready);
endinterface

### rtl/psv_cell.sv
// ----------------------------------------------------------------------------
// psv_cell
// One voice slot of the rotating voice ring.
// ----------------------------------------------------------------------------
module psv_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  psv_pkg::voice_t din,
    output psv_pkg::voice_t dout
);

    psv_pkg::voice_t voice_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
        end
        else if (shift)
        begin
            voice_reg <= din;
        end
    end

    assign dout = voice_reg;

endmodule

### rtl/psv_head.sv
// ----------------------------------------------------------------------------
// psv_head
// Update of the voice at the head of the ring for the current event.
// ----------------------------------------------------------------------------
module psv_head (
    input  psv_pkg::head_ctl_t ctl,
    input  psv_pkg::voice_t    vin,
    output psv_pkg::voice_t    vout,
    output psv_pkg::mix_entry_t entry
);

    logic                              hit;
    logic [psv_pkg::LEVEL_BITS:0]      rise;

    always_comb
    begin
        vout = vin;
        entry = '0;
        hit = vin.active
            && (ctl.key < 0 || $signed({1'b0, vin.key}) == ctl.key)
            && (ctl.tag < 0 || vin.tag < 0 || vin.tag == ctl.tag);
        rise = {1'b0, vin.level} + {1'b0, ctl.up};
        case (ctl.op)
            psv_pkg::OP_ON:
            begin
                if (ctl.slot == ctl.target)
                begin
                    vout.active = 1'b1;
                    vout.key = ctl.key[6:0];
                    vout.tag = ctl.tag;
                    vout.phase = '0;
                    vout.incr = ctl.incr;
                    vout.level = '0;
                    vout.stage = psv_pkg::STAGE_ATTACK;
                end
            end
            psv_pkg::OP_OFF:
            begin
                if (hit)
                begin
                    vout.stage = psv_pkg::STAGE_RELEASE;
                end
            end
            psv_pkg::OP_CHOKE:
            begin
                if (hit)
                begin
                    vout.active = 1'b0;
                end
            end
            psv_pkg::OP_TICK:
            begin
                if (vin.active)
                begin
                    entry.valid = 1'b1;
                    if (vin.stage == psv_pkg::STAGE_ATTACK)
                    begin
                        if (rise >= {1'b0, psv_pkg::ONE_Q23})
                        begin
                            vout.level = psv_pkg::ONE_Q23;
                            vout.stage = psv_pkg::STAGE_SUSTAIN;
                        end
                        else
                        begin
                            vout.level = rise[psv_pkg::LEVEL_BITS-1:0];
                        end
                    end
                    else if (vin.stage == psv_pkg::STAGE_RELEASE)
                    begin
                        if (vin.level <= ctl.down)
                        begin
                            vout.level = '0;
                            vout.active = 1'b0;
                            entry.valid = 1'b0;
                        end
                        else
                        begin
                            vout.level = vin.level - ctl.down;
                        end
                    end
                    if (entry.valid)
                    begin
                        vout.phase = vin.phase + vin.incr;
                    end
                    entry.idx = vin.phase[psv_pkg::PHASE_BITS-1 -: psv_pkg::SINE_TABLE_BITS];
                    entry.level = vout.level;
                end
            end
            default:
            begin
                vout = vin;
            end
        endcase
    end

endmodule

### rtl/psv_mix.sv
// ----------------------------------------------------------------------------
// psv_mix
// Sine lookup, envelope multiply and accumulation of the voice terms.
// ----------------------------------------------------------------------------
module psv_mix (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  psv_pkg::mix_entry_t                  entry,
    output logic signed [psv_pkg::ACC_BITS-1:0]  acc
);

    logic                                   v1_reg;
    logic signed [23:0]                     sine_reg;
    logic [psv_pkg::LEVEL_BITS-1:0]         lvl_reg;
    logic                                   v2_reg;
    logic signed [48:0]                     prod_reg;
    logic signed [48:0]                     prod_next;
    logic signed [48:0]                     rnd;
    logic signed [psv_pkg::ACC_BITS-1:0]    acc_reg;

    always_ff @(posedge clk)
    begin
        sine_reg <= psv_pkg::SINE_ROM[entry.idx];
        lvl_reg <= entry.level;
        prod_reg <= prod_next;
    end

    assign prod_next = sine_reg * $signed({1'b0, lvl_reg});
    assign rnd = (prod_reg + 49'sd4194304) >>> 23;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= entry.valid;
            v2_reg <= v1_reg;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg <= acc_reg + rnd[psv_pkg::ACC_BITS-1:0];
            end
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/poly_sine_voice_engine_unit.sv
// ----------------------------------------------------------------------------
// poly_sine_voice_engine_unit
// Sixteen-voice sine synthesizer with voice allocation and envelopes.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    mode, note_key, note_tag, midi_*, gain_value
//   out_ch    out   valid/ready    sample_out, voices_busy
//   apb       in    psel/penable   phase_scale, attack_step, release_step
//
// A tick passes through its transfer, one ring rotation with one voice per
// cycle through the head unit, the mix pipeline drain, the gain multiply
// and the output step. A note-on first finds a free slot and rounds its
// pitch; note-off and choke rotate only; gain and ignored events end in
// their transfer. Reset clears all voices; no clearing pass is needed.
// A stalled output holds the finished tick until its transfer, and a later
// tick waits in its output step until the output register is free.
// ----------------------------------------------------------------------------
module poly_sine_voice_engine_unit (
    input  logic         clk,
    input  logic         rst_n,
    psv_in_if.sink       in_ch,
    psv_out_if.source    out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    psv_pkg::state_t state_reg, state_next;
    psv_pkg::op_t    op_reg, op_next;
    logic signed [7:0]  key_reg, key_next;
    logic signed [31:0] tag_reg, tag_next;
    logic [psv_pkg::VOICE_BITS-1:0] cnt_reg, cnt_next;
    logic [psv_pkg::VOICE_BITS-1:0] target_reg, target_next;
    logic drain_reg, drain_next;
    logic [15:0] gain_reg, gain_next;
    logic [31:0] scale_reg;
    logic [23:0] attack_reg, release_reg;
    logic [48:0] pprod_reg;
    logic [4:0]  pshift_reg;
    logic [psv_pkg::PHASE_BITS-1:0] incr_reg;
    logic [4:0] busy_reg, busy_next;
    logic signed [45:0] scaled_reg;
    logic out_valid_reg, out_valid_next;
    logic signed [23:0] sample_reg, sample_next;
    logic [4:0] busy_out_reg, busy_out_next;

    logic shift;
    logic clear;
    logic wr;
    logic [8:0] kt;
    logic [49:0] pround;
    logic signed [26:0] srnd;
    logic [psv_pkg::LEVEL_BITS-1:0] up, down;
    logic signed [psv_pkg::ACC_BITS-1:0] acc;
    psv_pkg::voice_t ring [psv_pkg::VOICES];
    psv_pkg::voice_t head_out;
    psv_pkg::head_ctl_t ctl;
    psv_pkg::mix_entry_t entry;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= psv_pkg::PHASE_SCALE_RESET;
            attack_reg <= psv_pkg::ATTACK_RESET;
            release_reg <= psv_pkg::RELEASE_RESET;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                psv_pkg::REG_PHASE_SCALE: scale_reg <= pwdata;
                psv_pkg::REG_ATTACK:      attack_reg <= pwdata[23:0];
                psv_pkg::REG_RELEASE:     release_reg <= pwdata[23:0];
                default:                  scale_reg <= scale_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            psv_pkg::REG_PHASE_SCALE: prdata = scale_reg;
            psv_pkg::REG_ATTACK:      prdata = {8'd0, attack_reg};
            psv_pkg::REG_RELEASE:     prdata = {8'd0, release_reg};
            default:                  prdata = '0;
        endcase
    end

    assign up = (attack_reg == '0) ? 24'd1 :
                (attack_reg > psv_pkg::ONE_Q23) ? psv_pkg::ONE_Q23 : attack_reg;
    assign down = (release_reg == '0) ? 24'd1 :
                  (release_reg > psv_pkg::ONE_Q23) ? psv_pkg::ONE_Q23 : release_reg;

    assign shift = (state_reg == psv_pkg::ST_RUN);

    genvar gi;
    generate
        for (gi = 0; gi < psv_pkg::VOICES; gi++)
        begin : g_cell
            if (gi == psv_pkg::VOICES - 1)
            begin : g_last
                psv_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .din(head_out), .dout(ring[gi])
                );
            end
            else
            begin : g_mid
                psv_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .din(ring[gi+1]), .dout(ring[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        ctl.op = shift ? op_reg : psv_pkg::OP_NONE;
        ctl.key = key_reg;
        ctl.tag = tag_reg;
        ctl.slot = cnt_reg;
        ctl.target = target_reg;
        ctl.incr = incr_reg;
        ctl.up = up;
        ctl.down = down;
    end

    psv_head u_head (
        .ctl(ctl),
        .vin(ring[0]),
        .vout(head_out),
        .entry(entry)
    );

    psv_mix u_mix (
        .clk(clk),
        .rst_n(rst_n),
        .clear(clear),
        .entry(entry),
        .acc(acc)
    );

    assign kt = psv_pkg::KEY_TAB[key_reg[6:0]];
    assign pround = {1'b0, pprod_reg} + (50'd1 << (pshift_reg - 5'd1));

    always_ff @(posedge clk)
    begin
        pprod_reg <= scale_reg * psv_pkg::SEMI_Q16[kt[8:5]];
        pshift_reg <= kt[4:0];
        if (state_reg == psv_pkg::ST_ROUND)
        begin
            incr_reg <= psv_pkg::PHASE_BITS'(pround >> pshift_reg);
        end
        scaled_reg <= acc * $signed({1'b0, gain_reg});
        sample_reg <= sample_next;
        busy_out_reg <= busy_out_next;
    end

    assign srnd = 27'((scaled_reg + 46'sd262144) >>> 19);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psv_pkg::ST_IDLE;
            op_reg <= psv_pkg::OP_NONE;
            key_reg <= '0;
            tag_reg <= '0;
            cnt_reg <= '0;
            target_reg <= '0;
            drain_reg <= 1'b0;
            gain_reg <= psv_pkg::GAIN_RESET;
            busy_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            key_reg <= key_next;
            tag_reg <= tag_next;
            cnt_reg <= cnt_next;
            target_reg <= target_next;
            drain_reg <= drain_next;
            gain_reg <= gain_next;
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        tag_next = tag_reg;
        cnt_next = cnt_reg;
        target_next = target_reg;
        drain_next = drain_reg;
        gain_next = gain_reg;
        busy_next = busy_reg;
        out_valid_next = out_valid_reg;
        sample_next = sample_reg;
        busy_out_next = busy_out_reg;
        clear = 1'b0;
        in_ch.ready = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            psv_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                cnt_next = '0;
                if (in_ch.valid)
                begin
                    key_next = in_ch.note_key;
                    tag_next = in_ch.note_tag;
                    case (in_ch.mode)
                        psv_pkg::MODE_TICK:
                        begin
                            op_next = psv_pkg::OP_TICK;
                            clear = 1'b1;
                            busy_next = '0;
                            state_next = psv_pkg::ST_RUN;
                        end
                        psv_pkg::MODE_ON:
                        begin
                            if (!in_ch.note_key[7])
                            begin
                                op_next = psv_pkg::OP_ON;
                                state_next = psv_pkg::ST_PITCH;
                            end
                        end
                        psv_pkg::MODE_OFF:
                        begin
                            op_next = psv_pkg::OP_OFF;
                            state_next = psv_pkg::ST_RUN;
                        end
                        psv_pkg::MODE_CHOKE:
                        begin
                            op_next = psv_pkg::OP_CHOKE;
                            state_next = psv_pkg::ST_RUN;
                        end
                        psv_pkg::MODE_MIDI:
                        begin
                            key_next = {1'b0, in_ch.midi_data1};
                            tag_next = -32'sd1;
                            if (in_ch.midi_status[7:4] == psv_pkg::MIDI_NOTE_ON
                                && in_ch.midi_data2 != '0)
                            begin
                                op_next = psv_pkg::OP_ON;
                                state_next = psv_pkg::ST_PITCH;
                            end
                            else if (in_ch.midi_status[7:4] == psv_pkg::MIDI_NOTE_OFF
                                     || in_ch.midi_status[7:4] == psv_pkg::MIDI_NOTE_ON)
                            begin
                                op_next = psv_pkg::OP_OFF;
                                state_next = psv_pkg::ST_RUN;
                            end
                        end
                        psv_pkg::MODE_GAIN:
                        begin
                            gain_next = (in_ch.gain_value > psv_pkg::GAIN_ONE)
                                        ? psv_pkg::GAIN_ONE : in_ch.gain_value;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                end
            end
            psv_pkg::ST_PITCH:
            begin
                target_next = '0;
                for (int i = psv_pkg::VOICES - 1; i >= 0; i--)
                begin
                    if (!ring[i].active)
                    begin
                        target_next = psv_pkg::VOICE_BITS'(i);
                    end
                end
                state_next = psv_pkg::ST_ROUND;
            end
            psv_pkg::ST_ROUND:
            begin
                state_next = psv_pkg::ST_RUN;
            end
            psv_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (entry.valid)
                begin
                    busy_next = busy_reg + 5'd1;
                end
                if (cnt_reg == psv_pkg::VOICE_BITS'(psv_pkg::VOICES - 1))
                begin
                    drain_next = 1'b0;
                    state_next = (op_reg == psv_pkg::OP_TICK) ? psv_pkg::ST_DRAIN
                                                              : psv_pkg::ST_IDLE;
                end
            end
            psv_pkg::ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = psv_pkg::ST_SCALE;
                end
            end
            psv_pkg::ST_SCALE:
            begin
                state_next = psv_pkg::ST_OUT;
            end
            psv_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    busy_out_next = busy_reg;
                    if (srnd > 27'sd8388607)
                    begin
                        sample_next = 24'sd8388607;
                    end
                    else if (srnd < -27'sd8388608)
                    begin
                        sample_next = -24'sd8388608;
                    end
                    else
                    begin
                        sample_next = srnd[23:0];
                    end
                    state_next = psv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psv_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.sample_out = sample_reg;
    assign out_ch.voices_busy = busy_out_reg;

endmodule

### rtl/psv_checker.sv
// ----------------------------------------------------------------------------
// psv_checker
// Port-level checks of the voice engine, bound to the top level.
// ----------------------------------------------------------------------------
module psv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [23:0] sample_out,
    input logic [4:0]         voices_busy
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(voices_busy))
        else $error("output changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> voices_busy <= 5'd16)
        else $error("busy count above voice count");

    a_late: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("sample appeared right after an input transfer");

endmodule

bind poly_sine_voice_engine_unit psv_checker u_psv_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sample_out(out_ch.sample_out),
    .voices_busy(out_ch.voices_busy)
);

### bench/tb_poly_sine_voice_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_poly_sine_voice_engine_unit
// Drives note, MIDI, gain and tick events into the voice engine, predicts each
// tick's sample and busy count with an independent voice model, and compares
// every output transfer against it under several idling patterns and register
// settings.
// ----------------------------------------------------------------------------
module tb_poly_sine_voice_engine_unit;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    psv_in_if in_ch ();
    psv_out_if out_ch ();

    poly_sine_voice_engine_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    typedef struct packed {
        logic signed [23:0] sample;
        logic [4:0]         busy;
    } tick_result_t;

    logic signed [23:0] sine_tab [psv_pkg::SINE_N];
    logic [16:0] semi_tab [12];

    logic [31:0] cfg_scale;
    logic [23:0] cfg_up;
    logic [23:0] cfg_down;
    logic [15:0] mdl_gain;
    logic        v_on [psv_pkg::VOICES];
    logic [6:0]  v_key [psv_pkg::VOICES];
    logic signed [31:0] v_tag [psv_pkg::VOICES];
    logic [31:0] v_phase [psv_pkg::VOICES];
    logic [31:0] v_inc [psv_pkg::VOICES];
    logic [23:0] v_level [psv_pkg::VOICES];
    logic [1:0]  v_stage [psv_pkg::VOICES];

    tick_result_t pending_samples [$];
    int errors = 0;
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct;
    int recv_stall_pct;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        tick_result_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                begin
                    $display("Unexpected transfer: sample %0d busy %0d",
                             out_ch.sample_out, out_ch.voices_busy);
                end
                mismatches++;
            end
            else
            begin
                exp_r = pending_samples.pop_front();
                if (exp_r.sample !== out_ch.sample_out || exp_r.busy !== out_ch.voices_busy)
                begin
                    errors++;
                    if (mismatches < 10)
                    begin
                        $display("Mismatch: expected sample %0d busy %0d, got %0d busy %0d",
                                 exp_r.sample, exp_r.busy, out_ch.sample_out,
                                 out_ch.voices_busy);
                    end
                    mismatches++;
                end
            end
        end
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [23:0] limit_step(logic [23:0] s);
        if (s == 0)
        begin
            return 24'd1;
        end
        return (s > psv_pkg::ONE_Q23) ? psv_pkg::ONE_Q23 : s;
    endfunction

    function automatic logic [31:0] key_increment(int k);
        int d;
        int oct;
        int semi;
        int sh;
        logic [63:0] prod;
        d = k - 69;
        if (d >= 0)
        begin
            oct = d / 12;
            semi = d % 12;
        end
        else
        begin
            oct = -((-d + 11) / 12);
            semi = d - 12 * oct;
        end
        sh = 16 - oct;
        prod = 64'(cfg_scale) * 64'(semi_tab[semi]);
        return 32'((prod + (64'd1 << (sh - 1))) >> sh);
    endfunction

    task automatic voice_start(int k, logic signed [31:0] tg);
        int v;
        v = 0;
        for (int i = psv_pkg::VOICES - 1; i >= 0; i--)
        begin
            if (!v_on[i])
            begin
                v = i;
            end
        end
        v_on[v] = 1'b1;
        v_key[v] = 7'(k);
        v_tag[v] = tg;
        v_phase[v] = '0;
        v_inc[v] = key_increment(k & 127);
        v_level[v] = '0;
        v_stage[v] = psv_pkg::STAGE_ATTACK;
    endtask

    task automatic voice_end(int k, logic signed [31:0] tg, bit choke);
        for (int i = 0; i < psv_pkg::VOICES; i++)
        begin
            if (v_on[i] && (k < 0 || int'(v_key[i]) == k) &&
                (tg < 0 || v_tag[i] < 0 || v_tag[i] == tg))
            begin
                if (choke)
                begin
                    v_on[i] = 1'b0;
                end
                else
                begin
                    v_stage[i] = psv_pkg::STAGE_RELEASE;
                end
            end
        end
    endtask

    task automatic predict_event(logic [2:0] md, logic signed [7:0] k, logic signed [31:0] tg,
                                 logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                                 logic [15:0] g);
        logic [23:0] up;
        logic [23:0] down;
        longint mix;
        longint s;
        int busy;
        tick_result_t r;
        case (md)
            psv_pkg::MODE_ON:
            begin
                if (k >= 0)
                begin
                    voice_start(int'(k), tg);
                end
            end
            psv_pkg::MODE_OFF: voice_end(int'(k), tg, 1'b0);
            psv_pkg::MODE_CHOKE: voice_end(int'(k), tg, 1'b1);
            psv_pkg::MODE_MIDI:
            begin
                if (st[7:4] == psv_pkg::MIDI_NOTE_ON && d2 != 0)
                begin
                    voice_start(int'(d1), -1);
                end
                else if (st[7:4] == psv_pkg::MIDI_NOTE_OFF || st[7:4] == psv_pkg::MIDI_NOTE_ON)
                begin
                    voice_end(int'(d1), -1, 1'b0);
                end
            end
            psv_pkg::MODE_GAIN: mdl_gain = (g > psv_pkg::GAIN_ONE) ? psv_pkg::GAIN_ONE : g;
            psv_pkg::MODE_TICK:
            begin
                up = limit_step(cfg_up);
                down = limit_step(cfg_down);
                mix = 0;
                busy = 0;
                for (int i = 0; i < psv_pkg::VOICES; i++)
                begin
                    if (!v_on[i])
                    begin
                        continue;
                    end
                    if (v_stage[i] == psv_pkg::STAGE_ATTACK)
                    begin
                        if (25'(v_level[i]) + 25'(up) >= 25'(psv_pkg::ONE_Q23))
                        begin
                            v_level[i] = psv_pkg::ONE_Q23;
                            v_stage[i] = psv_pkg::STAGE_SUSTAIN;
                        end
                        else
                        begin
                            v_level[i] = v_level[i] + up;
                        end
                    end
                    else if (v_stage[i] == psv_pkg::STAGE_RELEASE)
                    begin
                        if (v_level[i] <= down)
                        begin
                            v_level[i] = '0;
                            v_on[i] = 1'b0;
                            continue;
                        end
                        v_level[i] = v_level[i] - down;
                    end
                    mix += round_shift(longint'(sine_tab[v_phase[i][31:22]]) *
                                       longint'(v_level[i]), 23);
                    v_phase[i] = v_phase[i] + v_inc[i];
                    busy++;
                end
                s = round_shift(mix * longint'(mdl_gain), 19);
                if (s > 8388607)
                begin
                    s = 8388607;
                end
                if (s < -8388608)
                begin
                    s = -8388608;
                end
                r.sample = 24'(s);
                r.busy = 5'(busy);
                pending_samples.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_event(logic [2:0] md, logic signed [7:0] k, logic signed [31:0] tg,
                              logic [7:0] st, logic [6:0] d1, logic [6:0] d2,
                              logic [15:0] g);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= md;
        in_ch.note_key <= k;
        in_ch.note_tag <= tg;
        in_ch.midi_status <= st;
        in_ch.midi_data1 <= d1;
        in_ch.midi_data2 <= d2;
        in_ch.gain_value <= g;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predict_event(md, k, tg, st, d1, d2, g);
    endtask

    task automatic send_tick();
        send_event(psv_pkg::MODE_TICK, 8'($urandom), $urandom, 8'($urandom), 7'($urandom),
                   7'($urandom), 16'($urandom));
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            psv_pkg::REG_PHASE_SCALE: cfg_scale = val;
            psv_pkg::REG_ATTACK: cfg_up = val[23:0];
            psv_pkg::REG_RELEASE: cfg_down = val[23:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] sc, logic [31:0] up, logic [31:0] dn);
        drain_and_settle();
        write_reg(psv_pkg::REG_PHASE_SCALE, sc);
        write_reg(psv_pkg::REG_ATTACK, up);
        write_reg(psv_pkg::REG_RELEASE, dn);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic test_directed();
        send_tick();
        send_event(psv_pkg::MODE_ON, 8'sd69, 32'sd5, 0, 0, 0, 0);
        send_event(psv_pkg::MODE_ON, 8'sd0, -32'sd1, 0, 0, 0, 0);
        send_event(psv_pkg::MODE_ON, 8'sd127, 32'h7FFFFFFF, 0, 0, 0, 0);
        send_event(psv_pkg::MODE_ON, -8'sd1, 32'sd3, 0, 0, 0, 0);
        send_event(psv_pkg::MODE_GAIN, 0, 0, 0, 0, 0, 16'hFFFF);
        repeat (3) send_tick();
        send_event(psv_pkg::MODE_OFF, 8'sd69, 32'sd5, 0, 0, 0, 0);
        send_tick();
        send_event(psv_pkg::MODE_CHOKE, -8'sd1, 32'sd9, 0, 0, 0, 0);
        send_tick();
        send_event(psv_pkg::MODE_MIDI, 0, 0, 8'h93, 7'd60, 7'd127, 0);
        send_event(psv_pkg::MODE_MIDI, 0, 0, 8'h9F, 7'd60, 7'd0, 0);
        send_event(psv_pkg::MODE_MIDI, 0, 0, 8'hB0, 7'd64, 7'd100, 0);
        send_event(psv_pkg::MODE_MIDI, 0, 0, 8'h85, 7'd64, 7'd1, 0);
        send_event(3'd6, 0, 0, 0, 0, 0, 0);
        send_event(3'd7, 0, 0, 0, 0, 0, 0);
        send_event(psv_pkg::MODE_GAIN, 0, 0, 0, 0, 0, 16'd0);
        send_tick();
        send_event(psv_pkg::MODE_GAIN, 0, 0, 0, 0, 0, 16'd32768);
        send_tick();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 40)
            begin
                send_tick();
            end
            else if (r < 58)
            begin
                send_event(psv_pkg::MODE_ON, 8'($urandom_range(127)),
                           ($urandom_range(3) == 0) ? -32'sd1 : 32'($urandom_range(7)),
                           8'($urandom), 7'($urandom), 7'($urandom), 16'($urandom));
            end
            else if (r < 68)
            begin
                send_event(psv_pkg::MODE_OFF,
                           ($urandom_range(2) == 0) ? -8'sd1 : 8'($urandom_range(127)),
                           ($urandom_range(2) == 0) ? 32'($urandom) : 32'($urandom_range(7)),
                           8'($urandom), 7'($urandom), 7'($urandom), 16'($urandom));
            end
            else if (r < 72)
            begin
                send_event(psv_pkg::MODE_CHOKE, 8'($urandom),
                           ($urandom_range(1)) ? 32'($urandom) : 32'($urandom_range(7)),
                           8'($urandom), 7'($urandom), 7'($urandom), 16'($urandom));
            end
            else if (r < 90)
            begin
                send_event(psv_pkg::MODE_MIDI, 8'($urandom), $urandom,
                           ($urandom_range(3) == 0) ? 8'($urandom)
                           : {($urandom_range(1) ? psv_pkg::MIDI_NOTE_ON
                                                 : psv_pkg::MIDI_NOTE_OFF), 4'($urandom)},
                           7'($urandom), ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom),
                           16'($urandom));
            end
            else if (r < 96)
            begin
                send_event(psv_pkg::MODE_GAIN, 8'($urandom), $urandom, 8'($urandom),
                           7'($urandom), 7'($urandom), 16'($urandom));
            end
            else
            begin
                send_event(3'($urandom_range(7, 6)), 8'($urandom), $urandom, 8'($urandom),
                           7'($urandom), 7'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_phase(int sidle, int rstall, int n);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        test_random(n);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.note_key = '0;
        in_ch.note_tag = '0;
        in_ch.midi_status = '0;
        in_ch.midi_data1 = '0;
        in_ch.midi_data2 = '0;
        in_ch.gain_value = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sine_tab = psv_pkg::SINE_ROM;
        semi_tab = psv_pkg::SEMI_Q16;
        cfg_scale = psv_pkg::PHASE_SCALE_RESET;
        cfg_up = psv_pkg::ATTACK_RESET;
        cfg_down = psv_pkg::RELEASE_RESET;
        mdl_gain = psv_pkg::GAIN_RESET;
        for (int i = 0; i < psv_pkg::VOICES; i++)
        begin
            v_on[i] = 1'b0;
            v_key[i] = '0;
            v_tag[i] = '0;
            v_phase[i] = '0;
            v_inc[i] = '0;
            v_level[i] = '0;
            v_stage[i] = psv_pkg::STAGE_ATTACK;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        configure(32'hFFFFFFFF, 32'd8388608, 32'd8388608);
        test_phase(0, 0, 60);
        configure(32'd1, 32'd0, 32'd0);
        test_phase(85, 0, 60);
        configure(32'd39370534, 32'hFFFFFF, 32'd1);
        test_phase(0, 85, 80);
        configure($urandom, 32'd400000, 32'd600000);
        test_phase(28, 28, 80);
        configure(32'h40000000, 32'd1000000, 32'd2000000);
        test_phase(0, 0, 150);

        drain_and_settle();
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
